// ===== rtl/siq_pkg.sv =====
`timescale 1ns / 1ps

package siq_pkg;

  // Queue depth and derived widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ValW  = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Broadcast control to every cell
  typedef struct packed {
    logic                   ins;   // insert item this cycle
    logic                   del;   // shift whole chain towards the head
    logic signed [ValW-1:0] item;
  } cell_ctl_t;

endpackage

// ===== rtl/siq_cell.sv =====
`timescale 1ns / 1ps

module siq_cell (
  input  logic                           clk_i,
  input  siq_pkg::cell_ctl_t             ctl_i,
  input  logic                           occ_i,       // this cell holds a live entry
  input  logic                           left_occ_i,  // neighbour towards head is live
  input  logic                           left_gt_i,   // neighbour towards head > item
  input  logic signed [siq_pkg::ValW-1:0] left_val_i,
  input  logic signed [siq_pkg::ValW-1:0] right_val_i,
  output logic                           gt_o,
  output logic signed [siq_pkg::ValW-1:0] val_o
);
  import siq_pkg::*;

  logic signed [ValW-1:0] val_q, val_d;

  // Live entry strictly greater than the new item: it must move one place back
  assign gt_o  = occ_i && (val_q > ctl_i.item);
  assign val_o = val_q;

  // Shift/insert selection
  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || (!occ_i && left_occ_i)) begin
        val_d = ctl_i.item;
      end
    end else if (ctl_i.del) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/sorted_insert_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Word
// request   in         start_i while !busy_o     req_type_i, item_value_i
// result    out        result_valid_o strobe     result_value_o, status_o, occupancy_o
//
// One request per clock: the cell chain compares every entry with the item
// at once, so busy_o stays low and a result appears the cycle after start_i.
// Reset (rst_ni low, asynchronous) empties the queue; entry storage is not
// cleared, only the occupancy count. The receiver cannot stall: each result
// word is shown for exactly one cycle.

module sorted_insert_priority_queue_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      req_type_i,
  input  logic signed [siq_pkg::ValW-1:0] item_value_i,
  output logic                            result_valid_o,
  output logic signed [siq_pkg::ValW-1:0] result_value_o,
  output logic [1:0]                      status_o,
  output logic [siq_pkg::CntW-1:0]        occupancy_o
);
  import siq_pkg::*;

  req_e                   req;
  logic                   accept;
  logic                   empty, full;
  cell_ctl_t              ctl;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   vld_q, vld_d;
  logic signed [ValW-1:0] res_q, res_d;
  status_e                st_q, st_d;

  logic [DEPTH-1:0]       gt;
  logic [DEPTH-1:0]       occ;
  logic signed [ValW-1:0] val [DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign req    = req_e'(req_type_i);
  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == CntW'(DEPTH));

  // Request decode and result word
  always_comb begin
    ctl.ins  = 1'b0;
    ctl.del  = 1'b0;
    ctl.item = item_value_i;
    cnt_d    = cnt_q;
    res_d    = '0;
    st_d     = ST_OK;
    if (accept) begin
      unique case (req)
        REQ_ENQ: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        REQ_DEQ, REQ_PEEK: begin
          if (empty) begin
            res_d = '1;
            st_d  = ST_EMPTY;
          end else begin
            res_d = val[0];
            if (req == REQ_DEQ) begin
              ctl.del = 1'b1;
              cnt_d   = cnt_q - 1'b1;
            end
          end
        end
        default: begin
          st_d = ST_OK;
        end
      endcase
    end
  end

  assign vld_d = accept;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic                   l_occ, l_gt;
    logic signed [ValW-1:0] l_val, r_val;

    assign occ[i] = (Idx < cnt_q);

    if (i == 0) begin : g_head
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
      assign l_val = val[i];
    end else begin : g_body
      assign l_occ = occ[i-1];
      assign l_gt  = gt[i-1];
      assign l_val = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_val = val[i];
    end else begin : g_mid
      assign r_val = val[i+1];
    end

    siq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ[i]),
      .left_occ_i  (l_occ),
      .left_gt_i   (l_gt),
      .left_val_i  (l_val),
      .right_val_i (r_val),
      .gt_o        (gt[i]),
      .val_o       (val[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    st_q  <= st_d;
  end

  assign result_valid_o = vld_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;
  assign occupancy_o    = cnt_q;

endmodule
